### rtl/glyph_quad_emitter_macros.svh
// ----------------------------------------------------------------------------
// glyph quad emitter assertion macros
// shared concurrent checks, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_EMITTER_MACROS_SVH
`define GLYPH_QUAD_EMITTER_MACROS_SVH

// same-cycle implication
`define GQE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gqe_pkg.sv
// ----------------------------------------------------------------------------
// gqe_pkg
// types, constants and the corner table of the glyph quad emitter
// ----------------------------------------------------------------------------
package gqe_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;
    localparam int OUT_BITS        = 16;
    localparam int TEX_BITS        = 9;
    localparam int VERT_CNT_BITS   = 3;

    localparam logic [VERT_CNT_BITS-1:0] LAST_VERT = 3'd5;

    localparam logic [7:0] CODE_NUL     = 8'd0;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_CHAR  = 2'd2
    } opcode_t;

    // one glyph table entry
    typedef struct packed {
        logic [7:0] ax;
        logic [7:0] ay;
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] ox;
        logic [7:0] oy;
        logic [7:0] adv;
    } glyph_t;

    // the box of one character, handed to the vertex emitter
    typedef struct packed {
        logic                missing;
        logic [OUT_BITS-1:0] x0;
        logic [OUT_BITS-1:0] x1;
        logic [OUT_BITS-1:0] y0;
        logic [OUT_BITS-1:0] y1;
        logic [TEX_BITS-1:0] u0;
        logic [TEX_BITS-1:0] u1;
        logic [TEX_BITS-1:0] v0;
        logic [TEX_BITS-1:0] v1;
    } quad_t;

    // two triangles: corners 0,1,2 then 0,2,3
    function automatic logic [1:0] corner_of(input logic [VERT_CNT_BITS-1:0] idx);
        logic [1:0] c;
        case (idx)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/gqe_ram.sv
// ----------------------------------------------------------------------------
// gqe_ram
// simple dual-port RAM, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module gqe_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/gqe_emit.sv
// ----------------------------------------------------------------------------
// gqe_emit
// holds one character box and walks it out as six vertices, or one
// missing-glyph result
// ----------------------------------------------------------------------------
module gqe_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  gqe_pkg::quad_t                       quad,
    output logic                                 free,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 status,
    output logic signed [gqe_pkg::OUT_BITS-1:0]  pos_x,
    output logic signed [gqe_pkg::OUT_BITS-1:0]  pos_y,
    output logic [gqe_pkg::TEX_BITS-1:0]         tex_u,
    output logic [gqe_pkg::TEX_BITS-1:0]         tex_v,
    output logic                                 last
);

    gqe_pkg::quad_t                      quad_reg;
    logic                                valid_reg;
    logic                                valid_next;
    logic [gqe_pkg::VERT_CNT_BITS-1:0]   cnt_reg;
    logic [gqe_pkg::VERT_CNT_BITS-1:0]   cnt_next;
    logic [1:0]                          corner;
    logic                                right;
    logic                                bottom;
    logic                                take;

    assign corner = gqe_pkg::corner_of(cnt_reg);
    assign right  = (corner == 2'd2) || (corner == 2'd3);
    assign bottom = (corner == 2'd1) || (corner == 2'd2);

    assign last      = quad_reg.missing || (cnt_reg == gqe_pkg::LAST_VERT);
    assign out_valid = valid_reg;
    assign take      = valid_reg && !out_stall;
    assign free      = !valid_reg || (take && last);

    assign status = quad_reg.missing;
    assign pos_x  = right  ? quad_reg.x1 : quad_reg.x0;
    assign pos_y  = bottom ? quad_reg.y1 : quad_reg.y0;
    assign tex_u  = right  ? quad_reg.u1 : quad_reg.u0;
    assign tex_v  = bottom ? quad_reg.v1 : quad_reg.v0;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
        end
    end

endmodule

### rtl/glyph_quad_emitter.sv
// ----------------------------------------------------------------------------
// glyph_quad_emitter
// bitmap font glyph table and quad vertex generator
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall) takes one request per cycle while in_stall
// is low: glyph loads, begin-string and character requests. a load writes the
// glyph RAM at once; every request also goes through one request register where
// the pen and the stopped flag are updated in order.
// a drawn character yields six vertices (two triangles, corners 0,1,2,0,2,3)
// on the output channel (out_valid / out_stall), last set on the sixth; an
// unloaded glyph yields one result with status set. out_valid rises once the
// request has passed the request register and been loaded into the vertex emitter.
// throughput: loads, begin-string and characters that draw nothing move one per
// cycle while no drawn character waits ahead of them; a drawn character holds the
// vertex emitter for its six vertices, taken at the output channel's pace, and
// the next character enters as its last vertex leaves.
// when the receiver stalls, the current vertex holds and in_stall rises once
// a character waits in the request register.
// reset clears the glyph valid bits, the pen to (0, 0) and the stopped flag;
// the glyph RAM itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "glyph_quad_emitter_macros.svh"

module glyph_quad_emitter #(
    parameter int GLYPH_COUNT = gqe_pkg::GLYPH_COUNT_DEF,
    parameter int COORD_BITS  = gqe_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          opcode,
    input  logic [7:0]                          char_code,
    input  logic [7:0]                          atlas_x,
    input  logic [7:0]                          atlas_y,
    input  logic [7:0]                          glyph_width,
    input  logic [7:0]                          glyph_height,
    input  logic signed [7:0]                   offset_x,
    input  logic signed [7:0]                   offset_y,
    input  logic [7:0]                          advance,
    input  logic signed [15:0]                  start_x,
    input  logic signed [15:0]                  start_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status,
    output logic signed [gqe_pkg::OUT_BITS-1:0] pos_x,
    output logic signed [gqe_pkg::OUT_BITS-1:0] pos_y,
    output logic [gqe_pkg::TEX_BITS-1:0]        tex_u,
    output logic [gqe_pkg::TEX_BITS-1:0]        tex_v,
    output logic                                last
);

    // codes are eight bits, so no more than 256 entries are ever reached
    localparam int TABLE_DEPTH = (GLYPH_COUNT > 256) ? 256 : GLYPH_COUNT;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int WIDE_BITS   = (COORD_BITS > gqe_pkg::OUT_BITS) ?
                                 COORD_BITS : gqe_pkg::OUT_BITS;

    logic                        accept;
    logic                        code_ok;
    logic [ADDR_BITS-1:0]        addr;
    gqe_pkg::glyph_t             wr_glyph;
    gqe_pkg::glyph_t             rd_glyph;
    logic [TABLE_DEPTH-1:0]      gvalid_reg;
    logic [TABLE_DEPTH-1:0]      gvalid_next;

    // request register
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [1:0]                  s1_op_reg;
    logic [7:0]                  s1_code_reg;
    logic                        s1_hit_reg;
    logic signed [15:0]          s1_sx_reg;
    logic signed [15:0]          s1_sy_reg;

    logic [COORD_BITS-1:0]       pen_x_reg;
    logic [COORD_BITS-1:0]       pen_x_next;
    logic [COORD_BITS-1:0]       pen_y_reg;
    logic [COORD_BITS-1:0]       pen_y_next;
    logic                        stopped_reg;
    logic                        stopped_next;

    logic                        is_char;
    logic                        is_term;
    logic                        emits;
    logic                        s1_adv;
    logic                        q_load;
    logic                        emit_free;
    gqe_pkg::quad_t              quad;

    logic [COORD_BITS-1:0]       x0;
    logic [COORD_BITS-1:0]       x1;
    logic [COORD_BITS-1:0]       y0;
    logic [COORD_BITS-1:0]       y1;
    logic [WIDE_BITS-1:0]        x0_w;
    logic [WIDE_BITS-1:0]        x1_w;
    logic [WIDE_BITS-1:0]        y0_w;
    logic [WIDE_BITS-1:0]        y1_w;
    logic [WIDE_BITS-1:0]        sx_w;
    logic [WIDE_BITS-1:0]        sy_w;

    assign code_ok  = (32'(char_code) < GLYPH_COUNT);
    assign addr     = char_code[ADDR_BITS-1:0];
    assign accept   = in_valid && !in_stall;
    assign in_stall = s1_valid_reg && !s1_adv;

    assign wr_glyph = '{ax: atlas_x, ay: atlas_y, w: glyph_width, h: glyph_height,
                        ox: offset_x, oy: offset_y, adv: advance};

    gqe_ram #(
        .WIDTH ($bits(gqe_pkg::glyph_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_glyph_ram (
        .clk     (clk),
        .wr_en   (accept && (opcode == gqe_pkg::OP_LOAD) && code_ok),
        .wr_addr (addr),
        .wr_data (wr_glyph),
        .rd_en   (accept && (opcode == gqe_pkg::OP_CHAR)),
        .rd_addr (addr),
        .rd_data (rd_glyph)
    );

    always_comb
    begin
        gvalid_next = gvalid_reg;
        if (accept && (opcode == gqe_pkg::OP_LOAD) && code_ok)
        begin
            gvalid_next[addr] = 1'b1;
        end
    end

    // request decode
    assign is_char = (s1_op_reg == gqe_pkg::OP_CHAR);
    assign is_term = (s1_code_reg == gqe_pkg::CODE_NUL) ||
                     (s1_code_reg == gqe_pkg::CODE_NEWLINE);
    assign emits   = is_char && !stopped_reg && !is_term;
    assign s1_adv  = s1_valid_reg && (!emits || emit_free);
    assign q_load  = s1_adv && emits;

    // glyph box from the pen
    assign x0 = pen_x_reg + {{(COORD_BITS-8){rd_glyph.ox[7]}}, rd_glyph.ox};
    assign y0 = pen_y_reg + {{(COORD_BITS-8){rd_glyph.oy[7]}}, rd_glyph.oy};
    assign x1 = x0 + COORD_BITS'(rd_glyph.w);
    assign y1 = y0 + COORD_BITS'(rd_glyph.h);
    assign x0_w = WIDE_BITS'(x0);
    assign x1_w = WIDE_BITS'(x1);
    assign y0_w = WIDE_BITS'(y0);
    assign y1_w = WIDE_BITS'(y1);

    always_comb
    begin
        quad = '0;
        if (!s1_hit_reg)
        begin
            quad.missing = 1'b1;
        end
        else
        begin
            quad.x0 = x0_w[gqe_pkg::OUT_BITS-1:0];
            quad.x1 = x1_w[gqe_pkg::OUT_BITS-1:0];
            quad.y0 = y0_w[gqe_pkg::OUT_BITS-1:0];
            quad.y1 = y1_w[gqe_pkg::OUT_BITS-1:0];
            quad.u0 = {1'b0, rd_glyph.ax};
            quad.u1 = {1'b0, rd_glyph.ax} + {1'b0, rd_glyph.w};
            quad.v0 = {1'b0, rd_glyph.ay};
            quad.v1 = {1'b0, rd_glyph.ay} + {1'b0, rd_glyph.h};
        end
    end

    assign sx_w = WIDE_BITS'(s1_sx_reg);
    assign sy_w = WIDE_BITS'(s1_sy_reg);

    // pen and stopped flag, updated as a request leaves the register
    always_comb
    begin
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        stopped_next = stopped_reg;
        if (s1_adv)
        begin
            case (s1_op_reg)
                gqe_pkg::OP_BEGIN:
                begin
                    pen_x_next   = sx_w[COORD_BITS-1:0];
                    pen_y_next   = sy_w[COORD_BITS-1:0];
                    stopped_next = 1'b0;
                end
                gqe_pkg::OP_CHAR:
                begin
                    if (!stopped_reg && is_term)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (emits && s1_hit_reg)
                    begin
                        pen_x_next = pen_x_reg + COORD_BITS'(rd_glyph.adv);
                    end
                end
                default:
                begin
                    stopped_next = stopped_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            gvalid_reg   <= '0;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            gvalid_reg   <= gvalid_next;
            pen_x_reg    <= pen_x_next;
            pen_y_reg    <= pen_y_next;
            stopped_reg  <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode;
            s1_code_reg <= char_code;
            s1_hit_reg  <= code_ok && gvalid_reg[addr];
            s1_sx_reg   <= start_x;
            s1_sy_reg   <= start_y;
        end
    end

    gqe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (q_load),
        .quad      (quad),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .last      (last)
    );

    `GQE_ASSERT_NOW(a_missing_is_last, clk, rst_n, out_valid && status, last,
        "missing-glyph result without last")
    `GQE_ASSERT_NOW(a_missing_is_zero, clk, rst_n, out_valid && status,
        (pos_x == '0) && (pos_y == '0) && (tex_u == '0) && (tex_v == '0),
        "missing-glyph result carries nonzero fields")
    `GQE_ASSERT_NOW(a_stall_needs_request, clk, rst_n, in_stall,
        s1_valid_reg && emits && out_valid,
        "input stalled without a character waiting on the emitter")
    `GQE_ASSERT_NEXT(a_drain_after_last, clk, rst_n,
        out_valid && !out_stall && last && !q_load, !out_valid,
        "output still valid after last vertex taken")

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// glyph quad emitter testbench
// drives glyph loads, begin-string and character requests from a queue,
// predicts every vertex and missing-glyph result in order and checks each
// accepted result field by field, under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // vertex slots that take the right or the bottom edge of the box
    localparam logic [5:0] RIGHT_VERTS  = 6'b110100;
    localparam logic [5:0] BOTTOM_VERTS = 6'b010110;

    typedef enum logic [1:0] {
        ENTRY_REQ,
        ENTRY_PHASE,
        ENTRY_HOLD
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t        kind;
        logic [6:0]         idle_pct;
        logic [6:0]         stall_pct;
        logic [1:0]         op;
        logic [7:0]         code;
        logic [7:0]         ax;
        logic [7:0]         ay;
        logic [7:0]         w;
        logic [7:0]         h;
        logic signed [7:0]  ox;
        logic signed [7:0]  oy;
        logic [7:0]         adv;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } glyph_req_t;

    typedef struct packed {
        logic                         status;
        logic [gqe_pkg::OUT_BITS-1:0] pos_x;
        logic [gqe_pkg::OUT_BITS-1:0] pos_y;
        logic [gqe_pkg::TEX_BITS-1:0] tex_u;
        logic [gqe_pkg::TEX_BITS-1:0] tex_v;
        logic                         last;
    } vertex_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [1:0]          opcode       = '0;
    logic [7:0]          char_code    = '0;
    logic [7:0]          atlas_x      = '0;
    logic [7:0]          atlas_y      = '0;
    logic [7:0]          glyph_width  = '0;
    logic [7:0]          glyph_height = '0;
    logic signed [7:0]   offset_x     = '0;
    logic signed [7:0]   offset_y     = '0;
    logic [7:0]          advance      = '0;
    logic signed [15:0]  start_x      = '0;
    logic signed [15:0]  start_y      = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                status;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic [8:0]          tex_u;
    logic [8:0]          tex_v;
    logic                last;

    glyph_req_t  req_pending [$];
    glyph_req_t  cur_req;
    glyph_req_t  scratch_req;
    vertex_t     vertex_expect [$];
    vertex_t     want_vtx;
    vertex_t     got_vtx;
    logic [7:0]  loaded_pool [$];

    // shadow of the block state
    gqe_pkg::glyph_t glyph_tbl [gqe_pkg::GLYPH_COUNT_DEF];
    bit              glyph_loaded [gqe_pkg::GLYPH_COUNT_DEF];
    logic [15:0]     pen_x = '0;
    logic [15:0]     pen_y = '0;
    logic            string_stopped = 1'b0;

    int reqs_total    = 0;
    int reqs_taken    = 0;
    int mismatches    = 0;
    int cycle_cnt     = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    glyph_quad_emitter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .char_code    (char_code),
        .atlas_x      (atlas_x),
        .atlas_y      (atlas_y),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .advance      (advance),
        .start_x      (start_x),
        .start_y      (start_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .last         (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // expected results of one accepted request, in order
    task automatic predict_glyph_quad(input glyph_req_t r);
        gqe_pkg::glyph_t g;
        vertex_t         v;
        logic [15:0]     x0;
        logic [15:0]     x1;
        logic [15:0]     y0;
        logic [15:0]     y1;
        logic [8:0]      u0;
        logic [8:0]      u1;
        logic [8:0]      v0;
        logic [8:0]      v1;
        int              k;
        case (r.op)
            gqe_pkg::OP_LOAD:
            begin
                glyph_tbl[r.code]    = '{r.ax, r.ay, r.w, r.h, r.ox, r.oy, r.adv};
                glyph_loaded[r.code] = 1'b1;
            end
            gqe_pkg::OP_BEGIN:
            begin
                pen_x          = r.sx;
                pen_y          = r.sy;
                string_stopped = 1'b0;
            end
            gqe_pkg::OP_CHAR:
            begin
                if (!string_stopped)
                begin
                    if (r.code == gqe_pkg::CODE_NUL || r.code == gqe_pkg::CODE_NEWLINE)
                    begin
                        string_stopped = 1'b1;
                    end
                    else if (!glyph_loaded[r.code])
                    begin
                        v        = '0;
                        v.status = 1'b1;
                        v.last   = 1'b1;
                        vertex_expect.insert(vertex_expect.size(), v);
                    end
                    else
                    begin
                        g  = glyph_tbl[r.code];
                        x0 = pen_x + {{8{g.ox[7]}}, g.ox};
                        y0 = pen_y + {{8{g.oy[7]}}, g.oy};
                        x1 = x0 + {8'd0, g.w};
                        y1 = y0 + {8'd0, g.h};
                        u0 = {1'b0, g.ax};
                        v0 = {1'b0, g.ay};
                        u1 = u0 + {1'b0, g.w};
                        v1 = v0 + {1'b0, g.h};
                        for (k = 0; k < 6; k++)
                        begin
                            v.status = 1'b0;
                            v.pos_x  = RIGHT_VERTS[k]  ? x1 : x0;
                            v.pos_y  = BOTTOM_VERTS[k] ? y1 : y0;
                            v.tex_u  = RIGHT_VERTS[k]  ? u1 : u0;
                            v.tex_v  = BOTTOM_VERTS[k] ? v1 : v0;
                            v.last   = (k == 5);
                            vertex_expect.insert(vertex_expect.size(), v);
                        end
                        pen_x = pen_x + {8'd0, g.adv};
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // driver: presents queued requests, holds each until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_glyph_quad(cur_req);
                reqs_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_pending.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (req_pending[0].kind == ENTRY_HOLD)
                begin
                    scratch_req = req_pending.pop_front();
                    hold_token <= hold_token + 1;
                    in_valid   <= 1'b0;
                end
                else if (req_pending[0].kind == ENTRY_PHASE)
                begin
                    // pause until every result so far has come out
                    if (vertex_expect.size() == 0)
                    begin
                        scratch_req = req_pending.pop_front();
                        in_idle_pct   <= int'(scratch_req.idle_pct);
                        out_stall_pct <= int'(scratch_req.stall_pct);
                    end
                    in_valid <= 1'b0;
                end
                else if ($urandom_range(99) < in_idle_pct)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_req = req_pending.pop_front();
                    in_valid     <= 1'b1;
                    opcode       <= cur_req.op;
                    char_code    <= cur_req.code;
                    atlas_x      <= cur_req.ax;
                    atlas_y      <= cur_req.ay;
                    glyph_width  <= cur_req.w;
                    glyph_height <= cur_req.h;
                    offset_x     <= cur_req.ox;
                    offset_y     <= cur_req.oy;
                    advance      <= cur_req.adv;
                    start_x      <= cur_req.sx;
                    start_y      <= cur_req.sy;
                end
            end
        end
    end

    // monitor: checks results and drives the receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_vtx = '{status, pos_x, pos_y, tex_u, tex_v, last};
                if (vertex_expect.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: status %0b pos %0d,%0d tex %0d,%0d last %0b",
                                 status, pos_x, pos_y, tex_u, tex_v, last);
                end
                else
                begin
                    want_vtx = vertex_expect.pop_front();
                    if (got_vtx !== want_vtx)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result mismatch: expected status %0b pos %0d,%0d ",
                                      "tex %0d,%0d last %0b, got status %0b pos %0d,%0d ",
                                      "tex %0d,%0d last %0b"},
                                     want_vtx.status, $signed(want_vtx.pos_x),
                                     $signed(want_vtx.pos_y), want_vtx.tex_u, want_vtx.tex_v,
                                     want_vtx.last, status, pos_x, pos_y, tex_u, tex_v, last);
                    end
                end
            end
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[glyph_quad_emitter] ERROR");
            $finish;
        end
    end

    function automatic glyph_req_t noise_req();
        glyph_req_t r;
        r.kind      = ENTRY_REQ;
        r.idle_pct  = '0;
        r.stall_pct = '0;
        r.op        = 2'($urandom_range(3));
        r.code      = 8'($urandom_range(255));
        r.ax        = 8'($urandom_range(255));
        r.ay        = 8'($urandom_range(255));
        r.w         = 8'($urandom_range(255));
        r.h         = 8'($urandom_range(255));
        r.ox        = 8'($urandom_range(255));
        r.oy        = 8'($urandom_range(255));
        r.adv       = 8'($urandom_range(255));
        r.sx        = 16'($urandom_range(65535));
        r.sy        = 16'($urandom_range(65535));
        return r;
    endfunction

    task automatic queue_req(input glyph_req_t r);
        req_pending.insert(req_pending.size(), r);
        reqs_total++;
    endtask

    task automatic queue_op(input logic [1:0] op, input logic [7:0] code);
        glyph_req_t r;
        r      = noise_req();
        r.op   = op;
        r.code = code;
        queue_req(r);
        if (op == gqe_pkg::OP_LOAD && code != gqe_pkg::CODE_NUL &&
            code != gqe_pkg::CODE_NEWLINE)
            loaded_pool.insert(loaded_pool.size(), code);
    endtask

    task automatic queue_begin(input logic [15:0] sx, input logic [15:0] sy);
        glyph_req_t r;
        r    = noise_req();
        r.op = gqe_pkg::OP_BEGIN;
        r.sx = sx;
        r.sy = sy;
        queue_req(r);
    endtask

    task automatic queue_marker(input entry_kind_t kind, input int idle, input int stall);
        glyph_req_t r;
        r           = noise_req();
        r.kind      = kind;
        r.idle_pct  = 7'(idle);
        r.stall_pct = 7'(stall);
        req_pending.insert(req_pending.size(), r);
    endtask

    function automatic logic [7:0] pick_code();
        int p;
        p = $urandom_range(99);
        if (p < 75)
            return loaded_pool[$urandom_range(loaded_pool.size() - 1)];
        else if (p < 90)
            return 8'($urandom_range(255));
        else if (p < 95)
            return gqe_pkg::CODE_NUL;
        else
            return gqe_pkg::CODE_NEWLINE;
    endfunction

    // mostly strings of drawable characters, some loads, some noise
    task automatic gen_traffic(input int n);
        int         made;
        int         pick;
        int         len;
        int         k;
        logic [7:0] code;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                queue_op(gqe_pkg::OP_LOAD, 8'($urandom_range(255)));
                made++;
            end
            else if (pick < 20)
            begin
                queue_op(OP_UNUSED, 8'($urandom_range(255)));
            end
            else
            begin
                if (pick < 90)
                begin
                    queue_begin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
                    made++;
                end
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    code = pick_code();
                    queue_op(gqe_pkg::OP_CHAR, code);
                    made++;
                    if (code == gqe_pkg::CODE_NUL || code == gqe_pkg::CODE_NEWLINE)
                        break;
                end
            end
        end
    endtask

    initial
    begin
        glyph_req_t r;
        int         k;

        // character before any load and before any begin string
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        r      = noise_req();
        r.op   = gqe_pkg::OP_LOAD;
        r.code = 8'd65;
        r.ax   = 8'hff;
        r.ay   = 8'hff;
        r.w    = 8'hff;
        r.h    = 8'hff;
        r.ox   = -8'sd128;
        r.oy   = 8'sd127;
        r.adv  = 8'hff;
        queue_req(r);
        loaded_pool.insert(loaded_pool.size(), 8'd65);
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        r      = noise_req();
        r.op   = gqe_pkg::OP_LOAD;
        r.code = 8'd66;
        r.ax   = '0;
        r.ay   = '0;
        r.w    = '0;
        r.h    = '0;
        r.ox   = 8'sd127;
        r.oy   = -8'sd128;
        r.adv  = '0;
        queue_req(r);
        loaded_pool.insert(loaded_pool.size(), 8'd66);
        // pen near the wrap points
        queue_begin(16'h7fff, 16'h8000);
        queue_op(gqe_pkg::OP_CHAR, 8'd66);
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        queue_op(OP_UNUSED, 8'd65);
        queue_op(gqe_pkg::OP_CHAR, gqe_pkg::CODE_NEWLINE);
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        queue_begin(16'h8000, 16'h7fff);
        queue_op(gqe_pkg::OP_CHAR, 8'd65);
        queue_op(gqe_pkg::OP_CHAR, gqe_pkg::CODE_NUL);
        queue_op(gqe_pkg::OP_CHAR, 8'd66);
        queue_op(gqe_pkg::OP_LOAD, 8'd255);
        // loaded terminator codes still end the string
        queue_op(gqe_pkg::OP_LOAD, gqe_pkg::CODE_NUL);
        queue_op(gqe_pkg::OP_LOAD, gqe_pkg::CODE_NEWLINE);
        queue_begin(16'h0000, 16'h0000);
        queue_op(gqe_pkg::OP_CHAR, 8'd255);
        queue_op(gqe_pkg::OP_CHAR, 8'd200);
        queue_op(gqe_pkg::OP_CHAR, gqe_pkg::CODE_NEWLINE);
        queue_begin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        queue_op(gqe_pkg::OP_CHAR, gqe_pkg::CODE_NUL);
        queue_begin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        queue_op(gqe_pkg::OP_CHAR, 8'd66);

        queue_marker(ENTRY_PHASE, 0, 0);
        gen_traffic(50);
        // long receiver hold while a long string keeps coming
        queue_marker(ENTRY_HOLD, 0, 0);
        queue_begin(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        for (k = 0; k < 30; k++)
            queue_op(gqe_pkg::OP_CHAR, loaded_pool[$urandom_range(loaded_pool.size() - 1)]);
        gen_traffic(30);
        queue_marker(ENTRY_PHASE, 63, 0);
        gen_traffic(80);
        queue_marker(ENTRY_PHASE, 0, 63);
        gen_traffic(80);
        queue_marker(ENTRY_PHASE, 33, 33);
        gen_traffic(40);
        queue_marker(ENTRY_PHASE, 33, 33);
        queue_marker(ENTRY_HOLD, 0, 0);
        gen_traffic(45);

        wait (rst_n === 1'b1);
        while (reqs_taken < reqs_total || vertex_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && vertex_expect.size() == 0)
            $display("[glyph_quad_emitter] OK");
        else
            $display("[glyph_quad_emitter] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/gqe_pkg.sv
rtl/gqe_ram.sv
rtl/gqe_emit.sv
rtl/glyph_quad_emitter.sv
tb/sv/testbench.sv
